### sv/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared constants and the byte-wise CRC-32C update for the chunked signer.
// ----------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

  // reflected Castagnoli polynomial
  localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;

  // default widths of the byte counter and the chunk index
  localparam int CHUNK_COUNT_WIDTH_DEF = 24;
  localparam int INDEX_WIDTH_DEF       = 16;

  // chunk size after reset, before truncation to the counter width
  localparam logic [31:0] CHUNK_BYTES_RESET = 32'd1048576;

  // one byte through the reflected crc, lsb first
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                              input logic [7:0]  data);
    logic [31:0] crc;
    crc = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC32C_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

### sv/ccs_byte_if.sv
// ----------------------------------------------------------------------------
// ccs_byte_if
// Valid/ready channel carrying one segment byte and its end-of-segment mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccs_byte_if;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       segment_end;

  modport source (output valid, output data_byte, output segment_end, input ready);
  modport sink   (input valid, input data_byte, input segment_end, output ready);

endinterface

`default_nettype wire

### sv/ccs_result_if.sv
// ----------------------------------------------------------------------------
// ccs_result_if
// Valid/ready channel carrying one chunk CRC result with its index and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccs_result_if #(
  parameter int INDEX_WIDTH = ccs_pkg::INDEX_WIDTH_DEF
);

  logic                   valid;
  logic                   ready;
  logic [31:0]            chunk_crc;
  logic [INDEX_WIDTH-1:0] chunk_number;
  logic                   partial_chunk;
  logic                   last_of_segment;

  modport source (output valid, output chunk_crc, output chunk_number,
                  output partial_chunk, output last_of_segment, input ready);
  modport sink   (input valid, input chunk_crc, input chunk_number,
                  input partial_chunk, input last_of_segment, output ready);

endinterface

`default_nettype wire

### sv/ccs_in_reg.sv
// ----------------------------------------------------------------------------
// ccs_in_reg
// Input register stage: captures one byte beat per cycle from the stream while downstream takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_in_reg (
  input  wire logic    clk,
  input  wire logic    rst,
  ccs_byte_if.sink     byte_in,
  ccs_byte_if.source   byte_out
);

  logic       valid_q;
  logic [7:0] data_byte_q;
  logic       segment_end_q;

  // stage frees up when empty or when its beat moves on
  assign byte_in.ready = !valid_q || byte_out.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (byte_in.ready) begin
      valid_q <= byte_in.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      data_byte_q   <= byte_in.data_byte;
      segment_end_q <= byte_in.segment_end;
    end
  end

  assign byte_out.valid       = valid_q;
  assign byte_out.data_byte   = data_byte_q;
  assign byte_out.segment_end = segment_end_q;

endmodule

`default_nettype wire

### sv/ccs_chunk_engine.sv
// ----------------------------------------------------------------------------
// ccs_chunk_engine
// Running CRC, chunk byte count and chunk index; closes chunks and forms
// the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_chunk_engine #(
  parameter int CHUNK_COUNT_WIDTH = ccs_pkg::CHUNK_COUNT_WIDTH_DEF,
  parameter int INDEX_WIDTH       = ccs_pkg::INDEX_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [CHUNK_COUNT_WIDTH-1:0] cfg_wdata,
  ccs_byte_if.sink                          byte_in,
  ccs_result_if.source                      result_out
);

  import ccs_pkg::*;

  logic [CHUNK_COUNT_WIDTH-1:0] chunk_bytes;
  logic [31:0]                  running_crc;
  logic [CHUNK_COUNT_WIDTH-1:0] bytes_in_chunk;
  logic [INDEX_WIDTH-1:0]       chunk_counter;

  logic [CHUNK_COUNT_WIDTH-1:0] size_eff;
  logic [31:0]                  crc_next;
  logic [CHUNK_COUNT_WIDTH-1:0] count_next;
  logic                         full;
  logic                         emit;
  logic                         fire;

  // chunk size register, a size of zero behaves as one
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes <= CHUNK_BYTES_RESET[CHUNK_COUNT_WIDTH-1:0];
    end else if (cfg_we) begin
      chunk_bytes <= cfg_wdata;
    end
  end

  assign size_eff = (chunk_bytes == '0) ? CHUNK_COUNT_WIDTH'(1) : chunk_bytes;

  // byte update and chunk close decision
  assign crc_next   = crc32c_byte(running_crc, byte_in.data_byte);
  assign count_next = bytes_in_chunk + CHUNK_COUNT_WIDTH'(1);
  assign full       = (count_next >= size_eff);
  assign emit       = full || byte_in.segment_end;

  // a beat without a result never waits on the output side
  assign byte_in.ready = !emit || result_out.ready;
  assign fire          = byte_in.valid && byte_in.ready;

  // result beat
  assign result_out.valid           = byte_in.valid && emit;
  assign result_out.chunk_crc       = crc_next;
  assign result_out.chunk_number    = chunk_counter;
  assign result_out.partial_chunk   = !full;
  assign result_out.last_of_segment = byte_in.segment_end;

  // chunk state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc    <= '0;
      bytes_in_chunk <= '0;
      chunk_counter  <= '0;
    end else if (fire) begin
      if (emit) begin
        running_crc    <= '0;
        bytes_in_chunk <= '0;
        if (byte_in.segment_end) begin
          chunk_counter <= '0;
        end else begin
          chunk_counter <= chunk_counter + INDEX_WIDTH'(1);
        end
      end else begin
        running_crc    <= crc_next;
        bytes_in_chunk <= count_next;
      end
    end
  end

endmodule

`default_nettype wire

### sv/ccs_out_reg.sv
// ----------------------------------------------------------------------------
// ccs_out_reg
// Output register stage: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_out_reg #(
  parameter int INDEX_WIDTH = ccs_pkg::INDEX_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  ccs_result_if.sink     result_in,
  ccs_result_if.source   result_out
);

  logic                   valid_q;
  logic [31:0]            chunk_crc_q;
  logic [INDEX_WIDTH-1:0] chunk_number_q;
  logic                   partial_chunk_q;
  logic                   last_of_segment_q;

  // room when empty or when the held beat leaves this cycle
  assign result_in.ready = !valid_q || result_out.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (result_in.ready) begin
      valid_q <= result_in.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (result_in.valid && result_in.ready) begin
      chunk_crc_q       <= result_in.chunk_crc;
      chunk_number_q    <= result_in.chunk_number;
      partial_chunk_q   <= result_in.partial_chunk;
      last_of_segment_q <= result_in.last_of_segment;
    end
  end

  assign result_out.valid           = valid_q;
  assign result_out.chunk_crc       = chunk_crc_q;
  assign result_out.chunk_number    = chunk_number_q;
  assign result_out.partial_chunk   = partial_chunk_q;
  assign result_out.last_of_segment = last_of_segment_q;

endmodule

`default_nettype wire

### sv/chunked_crc32c_signer.sv
// ----------------------------------------------------------------------------
// chunked_crc32c_signer
// Cuts a byte segment into chunks and signs each chunk with its CRC-32C.
// ----------------------------------------------------------------------------
// byte_in carries one segment byte per beat, segment_end marking the last
// byte. result_out carries one beat per finished chunk: the CRC-32C
// (reflected 0x82F63B78, init 0, no final xor), the chunk index within the
// segment, a partial flag for a short closing chunk and a last-of-segment
// flag. cfg_we/cfg_wdata set the chunk size in bytes; write it only while
// no bytes are in flight. A size of zero acts as one byte.
// Throughput is one byte per cycle except while a chunk-closing byte waits
// on a full result register: the CRC byte update is a single xor network
// between the input and result registers; a byte passes both, in that order.
// Reset clears the running CRC, byte count and chunk index, empties both
// register stages and loads the default chunk size.
// When the receiver stalls the result register holds its beat; bytes that
// close no chunk still flow, and the input stops only once a second result
// would need the full output register.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_crc32c_signer #(
  parameter int CHUNK_COUNT_WIDTH = ccs_pkg::CHUNK_COUNT_WIDTH_DEF,
  parameter int INDEX_WIDTH       = ccs_pkg::INDEX_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [CHUNK_COUNT_WIDTH-1:0] cfg_wdata,
  ccs_byte_if.sink                          byte_in,
  ccs_result_if.source                      result_out
);

  import ccs_pkg::*;

  ccs_byte_if                                 byte_q ();
  ccs_result_if #(.INDEX_WIDTH(INDEX_WIDTH)) result_d ();

  // input register
  ccs_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_in),
    .byte_out (byte_q)
  );

  // chunk state and crc update
  ccs_chunk_engine #(
    .CHUNK_COUNT_WIDTH (CHUNK_COUNT_WIDTH),
    .INDEX_WIDTH       (INDEX_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .byte_in    (byte_q),
    .result_out (result_d)
  );

  // result register
  ccs_out_reg #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .result_in  (result_d),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte segments into the chunked CRC-32C signer under a range of chunk
// sizes and checks every chunk signature beat against an in-bench predictor.
// A short stimulus table covers reset, size extremes and a mid-chunk size
// change; random segments, a receiver hold-off and a sender drain follow.
// ----------------------------------------------------------------------------

module testbench;

  import ccs_pkg::*;

  localparam int CW = CHUNK_COUNT_WIDTH_DEF;
  localparam int IW = INDEX_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_BYTES = 40;
  localparam logic [CW-1:0] SIZE_MAX = {CW{1'b1}};

  // one chunk signature as it leaves the block
  typedef struct packed {
    logic [31:0]   crc;
    logic [IW-1:0] idx;
    logic          partial;
    logic          last;
  } chunk_sig_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  // one row of the directed stimulus table
  typedef struct packed {
    row_kind_t     kind;
    logic [CW-1:0] size;
    logic [7:0]    data;
    logic          eos;
    logic          typed;
    chunk_sig_t    sig;
  } plan_row_t;

  localparam chunk_sig_t NO_SIG = '0;
  localparam int PLAN_ROWS = 26;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // reset size: single zero byte closes a short chunk
    '{ROW_BYTE, '0, 8'h00, 1'b1, 1'b1, '{32'h0, 16'd0, 1'b1, 1'b1}},
    '{ROW_BYTE, '0, 8'hFF, 1'b0, 1'b0, NO_SIG},
    '{ROW_BYTE, '0, 8'hA5, 1'b1, 1'b0, NO_SIG},
    // one byte per chunk
    '{ROW_CFG, 24'd1, 8'h00, 1'b0, 1'b0, NO_SIG},
    '{ROW_BYTE, '0, 8'h00, 1'b0, 1'b1, '{32'h0, 16'd0, 1'b0, 1'b0}},
    '{ROW_BYTE, '0, 8'h00, 1'b0, 1'b1, '{32'h0, 16'd1, 1'b0, 1'b0}},
    '{ROW_BYTE, '0, 8'hFF, 1'b1, 1'b0, NO_SIG},
    // zero size behaves as one
    '{ROW_CFG, 24'd0, 8'h00, 1'b0, 1'b0, NO_SIG},
    '{ROW_BYTE, '0, 8'h00, 1'b1, 1'b1, '{32'h0, 16'd0, 1'b0, 1'b1}},
    '{ROW_BYTE, '0, 8'h5A, 1'b0, 1'b0, NO_SIG},
    '{ROW_BYTE, '0, 8'h80, 1'b1, 1'b0, NO_SIG},
    // full chunk that is also the segment end
    '{ROW_CFG, 24'd4, 8'h00, 1'b0, 1'b0, NO_SIG},
    '{ROW_BYTE, '0, 8'h01, 1'b0, 1'b0, NO_SIG},
    '{ROW_BYTE, '0, 8'h02, 1'b0, 1'b0, NO_SIG},
    '{ROW_BYTE, '0, 8'h03, 1'b0, 1'b0, NO_SIG},
    '{ROW_BYTE, '0, 8'h04, 1'b1, 1'b0, NO_SIG},
    // open a chunk, then lower the size below its fill
    '{ROW_CFG, 24'd8, 8'h00, 1'b0, 1'b0, NO_SIG},
    '{ROW_BYTE, '0, 8'h11, 1'b0, 1'b0, NO_SIG},
    '{ROW_BYTE, '0, 8'h22, 1'b0, 1'b0, NO_SIG},
    '{ROW_BYTE, '0, 8'h33, 1'b0, 1'b0, NO_SIG},
    '{ROW_CFG, 24'd2, 8'h00, 1'b0, 1'b0, NO_SIG},
    '{ROW_BYTE, '0, 8'h44, 1'b0, 1'b0, NO_SIG},
    '{ROW_BYTE, '0, 8'h55, 1'b1, 1'b0, NO_SIG},
    // largest size
    '{ROW_CFG, SIZE_MAX, 8'h00, 1'b0, 1'b0, NO_SIG},
    '{ROW_BYTE, '0, 8'hFF, 1'b0, 1'b0, NO_SIG},
    '{ROW_BYTE, '0, 8'h00, 1'b1, 1'b0, NO_SIG}
  };

  logic          clk;
  logic          rst;
  logic          cfg_we;
  logic [CW-1:0] cfg_wdata;

  ccs_byte_if                        byte_ch ();
  ccs_result_if #(.INDEX_WIDTH(IW))  result_ch ();

  chunked_crc32c_signer #(
    .CHUNK_COUNT_WIDTH (CW),
    .INDEX_WIDTH       (IW)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .byte_in    (byte_ch),
    .result_out (result_ch)
  );

  // predictor state
  logic [CW-1:0] cfg_size;
  logic [31:0]   crc_run;
  logic [CW-1:0] fill;
  logic [IW-1:0] chunk_idx;

  chunk_sig_t pending_sigs [$];

  int  fail_count = 0;
  int  bytes_sent = 0;
  int  sigs_seen = 0;
  int  size_writes = 0;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;
  bit  hold_req = 1'b0;

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // reflected crc-32c, one data bit per step, lsb first
  function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r = r >> 1;
      if (fb) begin
        r = r ^ CRC32C_POLY;
      end
    end
    return r;
  endfunction

  // advance the chunk state by one byte; returns 1 when a chunk closes
  function automatic bit sign_byte(input logic [7:0] d, input logic eos,
                                   output chunk_sig_t sig);
    logic [CW-1:0] limit;
    bit            full;
    limit = (cfg_size == '0) ? CW'(1) : cfg_size;
    crc_run = crc_update(crc_run, d);
    fill = fill + CW'(1);
    full = (fill >= limit);
    sig = '0;
    if (!full && !eos) begin
      return 1'b0;
    end
    sig.crc = crc_run;
    sig.idx = chunk_idx;
    sig.partial = !full;
    sig.last = eos;
    crc_run = '0;
    fill = '0;
    chunk_idx = eos ? '0 : chunk_idx + IW'(1);
    return 1'b1;
  endfunction

  // offer one beat, wait for it to be taken, record its signature if any
  task automatic send_byte(input logic [7:0] d, input logic eos, input logic typed,
                           input chunk_sig_t given);
    chunk_sig_t sig;
    while (tx_idle_en && $urandom_range(99) < 27) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= d;
    byte_ch.segment_end <= eos;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
    if (sign_byte(d, eos, sig)) begin
      pending_sigs.push_back(typed ? given : sig);
    end
    @(negedge clk);
  endtask

  // stop sending and let every expected beat come out
  task automatic drain_results();
    byte_ch.valid <= 1'b0;
    while (pending_sigs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_size(input logic [CW-1:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_size = v;
    size_writes++;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        result_ch.ready <= !(rx_idle_en && $urandom_range(99) < 27);
      end
    end
  end

  // compare each signature beat with the oldest expectation
  always @(posedge clk) begin : sig_check
    chunk_sig_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_sigs.size() == 0) begin
        $error("unexpected chunk beat: crc %h index %0d", result_ch.chunk_crc,
               result_ch.chunk_number);
        fail_count++;
      end else begin
        want = pending_sigs.pop_front();
        sigs_seen++;
        if (result_ch.chunk_crc !== want.crc) begin
          $error("chunk_crc: expected %h, got %h", want.crc, result_ch.chunk_crc);
          fail_count++;
        end
        if (result_ch.chunk_number !== want.idx) begin
          $error("chunk_number: expected %0d, got %0d", want.idx, result_ch.chunk_number);
          fail_count++;
        end
        if (result_ch.partial_chunk !== want.partial) begin
          $error("partial_chunk: expected %b, got %b", want.partial,
                 result_ch.partial_chunk);
          fail_count++;
        end
        if (result_ch.last_of_segment !== want.last) begin
          $error("last_of_segment: expected %b, got %b", want.last,
                 result_ch.last_of_segment);
          fail_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // main sequence
  initial begin
    int sizes [10];
    int left;
    int eff;
    int len;
    bit paused;
    logic [CW-1:0] sz;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.segment_end = 1'b0;
    cfg_size = CHUNK_BYTES_RESET[CW-1:0];
    crc_run = '0;
    fill = '0;
    chunk_idx = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CFG) begin
        set_size(PLAN[i].size);
      end else begin
        send_byte(PLAN[i].data, PLAN[i].eos, PLAN[i].typed, PLAN[i].sig);
      end
    end

    // random segments under a sequence of chunk sizes
    sizes = '{1, 3, 16, 0, 7, 0, 2, 16777215, 5, 1048576};
    sizes[5] = $urandom_range(9, 40);
    paused = 1'b0;
    foreach (sizes[p]) begin
      sz = CW'(sizes[p]);
      set_size(sz);
      eff = (sizes[p] == 0) ? 1 : sizes[p];
      if (p == 0) begin
        hold_req = 1'b1;
      end
      if (p == 5) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      left = PHASE_BYTES;
      while (left > 0) begin
        // sender pause until everything has come out
        if (p == 4 && !paused && left <= PHASE_BYTES / 2) begin
          drain_results();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 85) begin
          len = (eff > 64) ? $urandom_range(1, 12) : $urandom_range(1, 3 * eff + 1);
          for (int j = 0; j < len && left > 0; j++) begin
            send_byte(8'($urandom_range(255)), j == len - 1, 1'b0, NO_SIG);
            left--;
          end
        end else begin
          send_byte(8'($urandom_range(255)), $urandom_range(3) == 0, 1'b0, NO_SIG);
          left--;
        end
      end
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
    end

    drain_results();
    repeat (8 * SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d bytes, checked %0d chunk signatures over %0d size settings",
             bytes_sent, sigs_seen, size_writes);
    $display("included zero and largest sizes, a size cut mid-chunk and long stalls");
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
